// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the blur block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Same-cycle (overlapping) implication checked at every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rstn, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rstn, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
    else $error("assertion failed");
`endif

// ===== hdl/gbn_pkg.sv =====
// Package with types and constants of the normalized Gaussian blur block.
`default_nettype none
package gbn_pkg;
  localparam int MaxCols   = 256;
  localparam int MaxRows   = 256;
  localparam int MaxRadius = 7;
  localparam logic [7:0] ChanMax = 8'd255;

  localparam logic [1:0] ModeWeight  = 2'd0;
  localparam logic [1:0] ModePixel   = 2'd1;
  localparam logic [1:0] ModeCompute = 2'd2;

  localparam logic [1:0] RegWidth  = 2'd0;
  localparam logic [1:0] RegHeight = 2'd1;
  localparam logic [1:0] RegRadius = 2'd2;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  column;
    logic [7:0]  row;
    logic [7:0]  red_in;
    logic [7:0]  green_in;
    logic [7:0]  blue_in;
    logic [15:0] weight;
  } in_word_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       zero_weight;
  } out_word_t;

  // Handshake between the accumulator and the divider.
  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctl_t;
endpackage
`default_nettype wire

// ===== hdl/gbn_divider.sv =====
// Restoring serial divider: three channel quotients one after another, clamped.
`default_nettype none
module gbn_divider #(
  parameter int SumW = 48,
  parameter int WsW  = 40
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [SumW-1:0] sr_i,
  input  wire logic [SumW-1:0] sg_i,
  input  wire logic [SumW-1:0] sb_i,
  input  wire logic [WsW-1:0]  sw_i,
  output gbn_pkg::div_ctl_t    ctl_o,
  output gbn_pkg::out_word_t   res_o
);
  localparam int CntW = $clog2(SumW + 1);

  logic [SumW-1:0] num_q, num_d;
  logic [SumW-1:0] sg_q, sb_q;
  logic [WsW:0]    rem_q, rem_d;
  logic [WsW-1:0]  den_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [1:0]      ch_q, ch_d;
  logic            busy_q, busy_d, done_q, done_d;
  logic [7:0]      r_q, g_q, r_d, g_d;
  gbn_pkg::out_word_t res_q, res_d;
  logic [WsW:0]    trial;
  logic [7:0]      qsat;
  logic [WsW:0]    shifted;

  // One quotient bit per cycle, quotient bits shift into the numerator.
  always_comb begin
    shifted = {rem_q[WsW-1:0], num_q[SumW-1]};
    trial   = shifted - {1'b0, den_q};
    num_d = num_q; rem_d = rem_q; cnt_d = cnt_q; ch_d = ch_q;
    busy_d = busy_q; done_d = 1'b0; r_d = r_q; g_d = g_q; res_d = res_q;
    qsat = 8'd0;
    if (start_i && !busy_q) begin
      busy_d = 1'b1; ch_d = 2'd0; cnt_d = '0;
      num_d = sr_i; rem_d = '0;
    end else if (busy_q) begin
      if (!trial[WsW]) begin
        rem_d = trial;
        num_d = {num_q[SumW-2:0], 1'b1};
      end else begin
        rem_d = shifted;
        num_d = {num_q[SumW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(SumW - 1)) begin
        qsat = (num_d[SumW-1:8] != '0) ? gbn_pkg::ChanMax : num_d[7:0];
        cnt_d = '0; rem_d = '0;
        case (ch_q)
          2'd0: begin r_d = qsat; ch_d = 2'd1; num_d = sg_q; end
          2'd1: begin g_d = qsat; ch_d = 2'd2; num_d = sb_q; end
          default: begin
            res_d = '{red_out: r_q, green_out: g_q, blue_out: qsat, zero_weight: 1'b0};
            busy_d = 1'b0; done_d = 1'b1;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0; ch_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d; ch_q <= ch_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d; rem_q <= rem_d; r_q <= r_d; g_q <= g_d; res_q <= res_d;
    if (start_i && !busy_q) begin
      den_q <= sw_i; sg_q <= sg_i; sb_q <= sb_i;
    end
  end

  assign ctl_o = '{start: start_i, busy: busy_q, done: done_q};
  assign res_o = res_q;
endmodule
`default_nettype wire

// ===== hdl/gbn_window.sv =====
// Frame and weight memories with the sequencer that walks the blur window.
`default_nettype none
module gbn_window #(
  parameter int MaxCols   = gbn_pkg::MaxCols,
  parameter int MaxRows   = gbn_pkg::MaxRows,
  parameter int MaxRadius = gbn_pkg::MaxRadius,
  parameter int SumW      = 48,
  parameter int WsW       = 40
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               go_i,
  input  gbn_pkg::in_word_t       word_i,
  input  wire logic [8:0]         width_i,
  input  wire logic [8:0]         height_i,
  input  wire logic [2:0]         radius_i,
  output logic                    busy_o,
  output logic                    sums_valid_o,
  output logic [SumW-1:0]         sr_o,
  output logic [SumW-1:0]         sg_o,
  output logic [SumW-1:0]         sb_o,
  output logic [WsW-1:0]          sw_o
);
  localparam int XW   = $clog2(MaxCols);
  localparam int YW   = $clog2(MaxRows);
  localparam int Side = MaxRadius + 1;
  localparam int OW   = $clog2(Side) < 1 ? 1 : $clog2(Side);
  localparam int WAW  = $clog2(Side * Side);
  localparam int RW   = $clog2(MaxRadius + 1) < 1 ? 1 : $clog2(MaxRadius + 1);
  localparam int CW   = 14;

  typedef enum logic [3:0] {
    SIdle = 4'b0001, SWalk = 4'b0010, SDrain = 4'b0100, SDone = 4'b1000
  } state_e;

  logic [23:0] frame_mem [MaxCols*MaxRows];
  logic [15:0] wt_mem [Side*Side];
  logic [23:0] px_q;
  logic [15:0] wt_q;

  state_e state_q, state_d;
  logic signed [CW-1:0] dx_q, dy_q, dx_d, dy_d, rr, x, y;
  logic [7:0] col_q, row_q;
  logic [RW-1:0] r_sat;
  logic [9:0] w_sat, h_sat;
  logic tap_ok, v1_q, v2_q;
  logic [OW-1:0] ax, ay;
  logic [SumW-1:0] sr_q, sg_q, sb_q;
  logic [WsW-1:0] sw_q;
  logic [31:0] wr_q, wg_q, wb_q;
  logic [15:0] wt2_q;
  logic [XW-1:0] xi;
  logic [YW-1:0] yi;

  // Saturate the registers to the store limits.
  always_comb begin
    r_sat = (32'(radius_i) > MaxRadius) ? RW'(MaxRadius) : RW'(radius_i);
    w_sat = (32'(width_i) > MaxCols) ? 10'(MaxCols) : 10'(width_i);
    h_sat = (32'(height_i) > MaxRows) ? 10'(MaxRows) : 10'(height_i);
    rr = CW'(r_sat);
    x  = CW'(col_q) + dx_q;
    y  = CW'(row_q) + dy_q;
    tap_ok = (x >= 0) && (y >= 0) && (x < CW'(w_sat)) && (y < CW'(h_sat));
    ax = OW'(dx_q < 0 ? -dx_q : dx_q);
    ay = OW'(dy_q < 0 ? -dy_q : dy_q);
    xi = XW'(x);
    yi = YW'(y);
  end

  // Window walk: one tap per cycle, memory reads are registered.
  always_comb begin
    state_d = state_q; dx_d = dx_q; dy_d = dy_q;
    case (state_q)
      SIdle: if (go_i && word_i.mode == gbn_pkg::ModeCompute) begin
        state_d = SWalk; dx_d = -rr; dy_d = -rr;
      end
      SWalk: begin
        if (dx_q == rr) begin
          dx_d = -rr; dy_d = dy_q + 1'b1;
          if (dy_q == rr) state_d = SDrain;
        end else begin
          dx_d = dx_q + 1'b1;
        end
      end
      SDrain: if (!v1_q && !v2_q) state_d = SDone;
      SDone: state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle; v1_q <= 1'b0; v2_q <= 1'b0;
    end else begin
      state_q <= state_d;
      v1_q <= (state_q == SWalk) && tap_ok;
      v2_q <= v1_q;
    end
  end

  // Loads write the memories; the walk reads them.
  always_ff @(posedge clk_i) begin
    if (go_i && state_q == SIdle) begin
      if (word_i.mode == gbn_pkg::ModeWeight && 32'(word_i.column) <= MaxRadius
          && 32'(word_i.row) <= MaxRadius)
        wt_mem[WAW'(32'(word_i.row) * Side + 32'(word_i.column))] <= word_i.weight;
      if (word_i.mode == gbn_pkg::ModePixel && 32'(word_i.column) < MaxCols
          && 32'(word_i.row) < MaxRows)
        frame_mem[{YW'(word_i.row), XW'(word_i.column)}] <=
          {word_i.red_in, word_i.green_in, word_i.blue_in};
      col_q <= word_i.column; row_q <= word_i.row;
    end
    px_q <= frame_mem[{yi, xi}];
    wt_q <= wt_mem[WAW'(32'(ay) * Side + 32'(ax))];
    dx_q <= dx_d; dy_q <= dy_d;
    // Products are registered before they join the sums.
    wr_q <= 32'(wt_q) * 32'(px_q[23:16]);
    wg_q <= 32'(wt_q) * 32'(px_q[15:8]);
    wb_q <= 32'(wt_q) * 32'(px_q[7:0]);
    wt2_q <= wt_q;
    if (state_q == SIdle) begin
      sr_q <= '0; sg_q <= '0; sb_q <= '0; sw_q <= '0;
    end else if (v2_q) begin
      sr_q <= sr_q + SumW'(wr_q); sg_q <= sg_q + SumW'(wg_q);
      sb_q <= sb_q + SumW'(wb_q); sw_q <= sw_q + WsW'(wt2_q);
    end
  end

  assign busy_o = (state_q != SIdle);
  assign sums_valid_o = (state_q == SDone);
  assign sr_o = sr_q; assign sg_o = sg_q; assign sb_o = sb_q; assign sw_o = sw_q;
endmodule
`default_nettype wire

// ===== hdl/gaussian_blur_normalized_top.sv =====
// Top level of the normalized Gaussian blur block.
// A compute word walks (2r+1)^2 taps at one frame memory read per cycle,
// drains through the memory read, product and accumulate registers, then runs
// three serial 48-step divisions. One result word is strobed by done_o for one
// cycle; the receiver cannot stall it, so it must be captured at that edge.
// start is taken only while busy is low.
`default_nettype none
`include "assert_macros.svh"
module gaussian_blur_normalized_top #(
  parameter int MaxCols   = gbn_pkg::MaxCols,
  parameter int MaxRows   = gbn_pkg::MaxRows,
  parameter int MaxRadius = gbn_pkg::MaxRadius
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start,
  output logic                busy,
  input  gbn_pkg::in_word_t   in_word_i,
  output logic                done_o,
  output gbn_pkg::out_word_t  out_word_o,
  input  wire logic           cfg_valid_i,
  output logic                cfg_ready_o,
  input  wire logic [1:0]     cfg_index_i,
  input  wire logic [8:0]     cfg_data_i
);
  localparam int SumW = 48;
  localparam int WsW  = 40;

  logic [8:0] width_q, height_q;
  logic [2:0] radius_q;
  logic win_busy, sums_valid, zero_q, zdone_q;
  logic [SumW-1:0] sr, sg, sb;
  logic [WsW-1:0] sw;
  gbn_pkg::div_ctl_t dctl;
  gbn_pkg::out_word_t dres;
  logic go;

  assign go = start && !busy;
  assign cfg_ready_o = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= 9'd256; height_q <= 9'd256; radius_q <= 3'd5;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        gbn_pkg::RegWidth:  width_q  <= cfg_data_i;
        gbn_pkg::RegHeight: height_q <= cfg_data_i;
        gbn_pkg::RegRadius: radius_q <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  gbn_window #(.MaxCols(MaxCols), .MaxRows(MaxRows), .MaxRadius(MaxRadius),
               .SumW(SumW), .WsW(WsW)) u_win (
    .clk_i, .rst_ni, .go_i(go), .word_i(in_word_i), .width_i(width_q),
    .height_i(height_q), .radius_i(radius_q), .busy_o(win_busy),
    .sums_valid_o(sums_valid), .sr_o(sr), .sg_o(sg), .sb_o(sb), .sw_o(sw));

  gbn_divider #(.SumW(SumW), .WsW(WsW)) u_div (
    .clk_i, .rst_ni, .start_i(sums_valid && sw != '0), .sr_i(sr), .sg_i(sg),
    .sb_i(sb), .sw_i(sw), .ctl_o(dctl), .res_o(dres));

  // A zero weight sum skips the divider and answers black.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) zdone_q <= 1'b0;
    else zdone_q <= sums_valid && sw == '0;
  end
  assign zero_q = zdone_q;

  assign busy = win_busy || dctl.busy || dctl.done || zdone_q;
  assign done_o = dctl.done || zero_q;
  assign out_word_o = zero_q ? gbn_pkg::out_word_t'{red_out: 8'd0, green_out: 8'd0,
                                                   blue_out: 8'd0, zero_weight: 1'b1}
                             : dres;

  `ASSERT_IMPL(a_one_done, clk_i, rst_ni, done_o, !(dctl.done && zero_q))
  `ASSERT_IMPL(a_busy_div, clk_i, rst_ni, dctl.busy, busy)
  `ASSERT_NEXT(a_start_busy, clk_i, rst_ni,
               go && in_word_i.mode == gbn_pkg::ModeCompute, busy)
endmodule
`default_nettype wire
